/* hw/rtl/sbd_pkg.sv */
// Shared types, constants and the channel scaling function for the frame decoder.
package sbd_pkg;

    // Frame layout
    localparam int FRAME_LEN    = 25;
    localparam int FRAME_ADDR_W = $clog2(FRAME_LEN);
    localparam int FIRST_DATA   = 1;
    localparam int LAST_DATA    = 22;
    localparam int FLAG_POS     = 23;
    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam int LOST_BIT     = 2;
    localparam int FS_BIT       = 3;

    // Channel unpacking
    localparam int NUM_CH  = 16;
    localparam int CH_W    = $clog2(NUM_CH);
    localparam int CH_BITS = 11;
    localparam int ACC_W   = CH_BITS - 1 + 8;
    localparam int CNT_W   = $clog2(ACC_W + 1);

    // Scaling: clamp to 173..1811, then (x-173)*1020/1638 + 990.
    // The divide is a multiply by ceil(2^21*1020/1638) and a shift, exact over 0..1638.
    localparam logic [10:0] CLAMP_LO    = 11'd173;
    localparam logic [10:0] CLAMP_HI    = 11'd1811;
    localparam logic [10:0] OUT_BASE    = 11'd990;
    localparam logic [31:0] SCALE_MUL   = 32'd1305919;
    localparam int          SCALE_SHIFT = 21;

    // Timing
    localparam int          MS_W          = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd100;
    localparam logic [15:0] MS_MAX        = 16'hFFFF;

    // Input and result kinds
    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_TICK   = 1'b1;
    localparam logic RES_CHANNEL = 1'b0;
    localparam logic RES_STATUS  = 1'b1;

    // Unpacker sequencer states
    typedef enum logic [1:0] {
        UNP_IDLE,
        UNP_SHIFT,
        UNP_LOAD
    } unp_state_t;

    // Channel request from the unpacker to the output stage
    typedef struct packed {
        logic                valid;
        logic [CH_W-1:0]     index;
        logic [CH_BITS-1:0]  raw;
        logic                last;
    } chan_req_t;

    function automatic logic [10:0] scale_raw(input logic [10:0] raw);
        logic [10:0] x;
        logic [31:0] prod;
        x = raw;
        if (x < CLAMP_LO) x = CLAMP_LO;
        if (x > CLAMP_HI) x = CLAMP_HI;
        prod = 32'(x - CLAMP_LO) * SCALE_MUL;
        return 11'(prod[31:SCALE_SHIFT]) + OUT_BASE;
    endfunction

endpackage

/* hw/rtl/sbus_frame_decoder_top.sv */
// Top level of the 16-channel serial frame decoder with failsafe timing.
//
//  channel  | handshake              | payload
//  ---------+------------------------+-------------------------------------------
//  in       | in_valid / in_ready    | kind, byte_value
//  out      | out_valid / out_ready  | result_kind, channel_index, raw_value,
//           |                        | scaled_value, frame_lost, failsafe, last
//  cfg      | cfg_we (no wait)       | cfg_wdata -> timeout_ms
//
// A tick's status result sits in the output register. The byte that completes a frame
// starts a sweep of the frame RAM: 22 byte reads, each issued before it is appended,
// and 16 channels handed out, each waiting while the output register is not free.
// in_ready is low during that sweep and while the output register holds an untaken result.
// Reset is asynchronous, active low; the frame RAM needs no clearing.
module sbus_frame_decoder_top
    import sbd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         kind,
    input  logic [7:0]   byte_value,
    output logic         out_valid,
    input  logic         out_ready,
    output logic         result_kind,
    output logic [3:0]   channel_index,
    output logic [10:0]  raw_value,
    output logic [10:0]  scaled_value,
    output logic         frame_lost,
    output logic         failsafe,
    output logic         last,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata
);

    logic [FRAME_ADDR_W-1:0] pos_reg, pos_next;
    logic [7:0]              flag_byte_reg, flag_byte_next;
    logic                    lost_reg, lost_next;
    logic                    fs_reg, fs_next;
    logic [MS_W-1:0]         ms_reg, ms_next;
    logic [MS_W-1:0]         timeout_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    res_kind_reg;
    logic [3:0]              ch_idx_reg;
    logic [10:0]             raw_reg;
    logic [10:0]             scaled_reg;
    logic                    res_lost_reg;
    logic                    res_fs_reg;
    logic                    res_last_reg;

    logic                    in_fire, tick_fire, byte_take, frame_done;
    logic                    slot_free;
    logic [MS_W-1:0]         ms_inc;
    logic                    unp_busy;
    logic                    rd_en;
    logic [FRAME_ADDR_W-1:0] rd_addr;
    logic [7:0]              rd_data;
    chan_req_t               chan;
    logic                    chan_fire;

    // Input request decode
    assign slot_free  = !out_valid_reg || out_ready;
    assign in_ready   = !unp_busy && slot_free;
    assign in_fire    = in_valid && in_ready;
    assign tick_fire  = in_fire && (kind == KIND_TICK);
    assign byte_take  = in_fire && (kind == KIND_BYTE) &&
                        !(pos_reg == '0 && byte_value != START_BYTE);
    assign frame_done = byte_take && (pos_reg == FRAME_ADDR_W'(FRAME_LEN - 1));
    assign ms_inc     = (ms_reg == MS_MAX) ? ms_reg : ms_reg + 1'b1;
    assign chan_fire  = chan.valid && slot_free;

    // Frame byte store
    sbd_ram #(
        .WIDTH (8),
        .DEPTH (FRAME_LEN)
    ) u_frame_ram (
        .clk     (clk),
        .wr_en   (byte_take),
        .wr_addr (pos_reg),
        .wr_data (byte_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Channel unpacking sequencer
    sbd_unpacker u_unpacker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (frame_done),
        .busy       (unp_busy),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .chan       (chan),
        .chan_ready (slot_free)
    );

    // Frame position, flags and elapsed time
    always_comb
    begin
        pos_next       = pos_reg;
        flag_byte_next = flag_byte_reg;
        lost_next      = lost_reg;
        fs_next        = fs_reg;
        ms_next        = ms_reg;
        if (tick_fire)
        begin
            ms_next = ms_inc;
        end
        if (byte_take)
        begin
            if (pos_reg == FRAME_ADDR_W'(FLAG_POS))
            begin
                flag_byte_next = byte_value;
            end
            if (frame_done)
            begin
                pos_next  = '0;
                lost_next = flag_byte_reg[LOST_BIT];
                fs_next   = flag_byte_reg[FS_BIT];
                ms_next   = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            flag_byte_reg <= '0;
            lost_reg      <= 1'b0;
            fs_reg        <= 1'b0;
            ms_reg        <= '0;
            timeout_reg   <= TIMEOUT_RESET;
        end
        else
        begin
            pos_reg       <= pos_next;
            flag_byte_reg <= flag_byte_next;
            lost_reg      <= lost_next;
            fs_reg        <= fs_next;
            ms_reg        <= ms_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

    // Output register: a status result on a tick, or a channel from the unpacker
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (tick_fire || chan_fire)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            res_kind_reg <= RES_STATUS;
            ch_idx_reg   <= '0;
            raw_reg      <= '0;
            scaled_reg   <= OUT_BASE;
            res_lost_reg <= lost_reg;
            res_fs_reg   <= fs_reg || (ms_inc > timeout_reg);
            res_last_reg <= 1'b1;
        end
        else if (chan_fire)
        begin
            // elapsed time was just cleared, so only the frame's bit counts
            res_kind_reg <= RES_CHANNEL;
            ch_idx_reg   <= 4'(chan.index);
            raw_reg      <= 11'(chan.raw);
            scaled_reg   <= scale_raw(11'(chan.raw));
            res_lost_reg <= lost_reg;
            res_fs_reg   <= fs_reg;
            res_last_reg <= chan.last;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_kind   = res_kind_reg;
    assign channel_index = ch_idx_reg;
    assign raw_value     = raw_reg;
    assign scaled_value  = scaled_reg;
    assign frame_lost    = res_lost_reg;
    assign failsafe      = res_fs_reg;
    assign last          = res_last_reg;

`ifndef SYNTHESIS
    // A completed frame starts the channel sweep at once
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> unp_busy)
        else $error("frame completed but unpacker idle");

    // No new request is taken while channels are still being produced
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !unp_busy && !chan.valid)
        else $error("input ready during channel sweep");

    // Elapsed time saturates instead of wrapping
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_fire && ms_reg == MS_MAX |=> ms_reg == MS_MAX)
        else $error("elapsed counter wrapped");

    // A completed frame clears elapsed time and the frame position
    assert property (@(posedge clk) disable iff (!rst_n)
        frame_done |=> ms_reg == '0 && pos_reg == '0)
        else $error("frame completion did not clear position and elapsed time");
`endif

endmodule

/* hw/rtl/sbd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
module sbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 25
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/sbd_unpacker.sv */
// Sweeps the stored frame bytes through a bit buffer and issues sixteen 11-bit channels.
module sbd_unpacker
    import sbd_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    output logic                    rd_en,
    output logic [FRAME_ADDR_W-1:0] rd_addr,
    input  logic [7:0]              rd_data,
    output chan_req_t               chan,
    input  logic                    chan_ready
);

    unp_state_t              state_reg, state_next;
    logic [ACC_W-1:0]        acc_reg, acc_next;
    logic [CNT_W-1:0]        nbits_reg, nbits_next;
    logic [FRAME_ADDR_W-1:0] addr_reg, addr_next;
    logic [CH_W-1:0]         ch_reg, ch_next;
    logic                    have_chan;

    assign have_chan = (nbits_reg >= CNT_W'(CH_BITS));

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= UNP_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Bit buffer and sweep counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nbits_reg <= '0;
            addr_reg  <= '0;
            ch_reg    <= '0;
        end
        else
        begin
            nbits_reg <= nbits_next;
            addr_reg  <= addr_next;
            ch_reg    <= ch_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    // Next state and outputs
    always_comb
    begin
        state_next = state_reg;
        acc_next   = acc_reg;
        nbits_next = nbits_reg;
        addr_next  = addr_reg;
        ch_next    = ch_reg;
        rd_en      = 1'b0;
        rd_addr    = addr_reg;
        chan.valid = 1'b0;
        chan.index = ch_reg;
        chan.raw   = acc_reg[CH_BITS-1:0];
        chan.last  = (ch_reg == CH_W'(NUM_CH - 1));
        unique case (state_reg)
            UNP_IDLE:
            begin
                if (start)
                begin
                    acc_next   = '0;
                    nbits_next = '0;
                    addr_next  = FRAME_ADDR_W'(FIRST_DATA);
                    ch_next    = '0;
                    state_next = UNP_SHIFT;
                end
            end
            UNP_SHIFT:
            begin
                if (have_chan)
                begin
                    // enough bits buffered: hand out one channel
                    chan.valid = 1'b1;
                    if (chan_ready)
                    begin
                        acc_next   = acc_reg >> CH_BITS;
                        nbits_next = nbits_reg - CNT_W'(CH_BITS);
                        ch_next    = ch_reg + 1'b1;
                        if (chan.last)
                        begin
                            state_next = UNP_IDLE;
                        end
                    end
                end
                else
                begin
                    // fetch the next data byte
                    rd_en      = 1'b1;
                    state_next = UNP_LOAD;
                end
            end
            UNP_LOAD:
            begin
                // append the byte above the bits already held, LSB first
                acc_next   = acc_reg | (ACC_W'(rd_data) << nbits_reg);
                nbits_next = nbits_reg + CNT_W'(8);
                addr_next  = addr_reg + 1'b1;
                state_next = UNP_SHIFT;
            end
            default:
            begin
                state_next = UNP_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != UNP_IDLE);

`ifndef SYNTHESIS
    // A load always follows the read issued in the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == UNP_LOAD |-> $past(rd_en))
        else $error("unpacker load without a preceding read");

    // Reads never leave the channel data bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (addr_reg >= FRAME_ADDR_W'(FIRST_DATA) &&
                   addr_reg <= FRAME_ADDR_W'(LAST_DATA)))
        else $error("unpacker read outside channel bytes");

    // The final channel handed out ends the sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        chan.valid && chan_ready && chan.last |=> state_reg == UNP_IDLE)
        else $error("unpacker still busy after last channel");

    // The bit buffer never holds more than a byte beyond a partial channel
    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> nbits_reg <= CNT_W'(ACC_W))
        else $error("unpacker bit buffer overflow");
`endif

endmodule
